/* sv/dt2r_pkg.sv */
// ---------------------------------------------------------------------------
// dt2r_pkg
// Shared types, fixed-point constants and constant functions for the drift
// time to radius converter.
// ---------------------------------------------------------------------------
`default_nettype none

package dt2r_pkg;

    // datapath widths
    localparam int C_ACC_W  = 64;   // Q35.28 curve values
    localparam int C_T_W    = 28;   // Q2.30 time, below 0.25 us
    localparam int C_DT_W   = 16;
    localparam int C_OFF_W  = 10;
    localparam int C_UM_W   = 13;
    localparam int C_PP_W   = 32 + C_T_W;   // half-word times time product

    // one in Q28
    localparam logic signed [63:0] C_Q28_ONE = 64'sd268435456;

    // polynomial coefficients in Q28, lowest power first
    localparam logic signed [63:0] C_COEF [0:9] = '{
        (64'sd140694 * C_Q28_ONE + 64'sd50000) / 64'sd100000,
        -((64'sd288673 * C_Q28_ONE + 64'sd500) / 64'sd1000),
        (64'sd223724 * C_Q28_ONE + 64'sd5) / 64'sd10,
        -(64'sd724749 * C_Q28_ONE),
        64'sd138739 * 64'sd100 * C_Q28_ONE,
        -(64'sd169746 * 64'sd1000 * C_Q28_ONE),
        64'sd134466 * 64'sd10000 * C_Q28_ONE,
        -(64'sd668268 * 64'sd10000 * C_Q28_ONE),
        64'sd189464 * 64'sd100000 * C_Q28_ONE,
        -(64'sd233756 * 64'sd100000 * C_Q28_ONE)
    };

    // curve end values in Q28
    localparam logic signed [63:0] C_V426 = (64'sd426 * C_Q28_ONE + 64'sd50) / 64'sd100;
    localparam logic signed [63:0] C_VTOP =
        (64'sd482767 * C_Q28_ONE + 64'sd50000) / 64'sd100000;

    // segment boundaries in 1/16 ns
    localparam logic signed [C_DT_W-1:0] C_DT_KNEE    = 16'sd248;
    localparam logic signed [C_DT_W-1:0] C_DT_POLY_LO = 16'sd320;
    localparam logic signed [C_DT_W-1:0] C_DT_POLY_HI = 16'sd1440;
    localparam logic signed [C_DT_W-1:0] C_DT_MID     = 16'sd1840;
    localparam logic signed [C_DT_W-1:0] C_DT_FLAT    = 16'sd2400;

    // line segment spans in 1/16 ns
    localparam logic [63:0] C_SPAN_LOW  = 64'd72;
    localparam logic [63:0] C_SPAN_HIGH = 64'd400;
    localparam logic [63:0] C_SPAN_TOP  = 64'd560;

    // line segment arithmetic widths
    localparam int C_NABS_W = 16;
    localparam int C_QA_W   = 32;
    localparam int C_RA_W   = 10;
    localparam int C_PROD_W = C_QA_W + C_NABS_W;
    localparam int C_Y_W    = C_RA_W + C_NABS_W;
    localparam int C_RCP_K  = C_Y_W + C_RA_W;
    localparam int C_RCP_W  = 30;
    localparam int C_RMUL_W = C_Y_W + C_RCP_W;
    localparam int C_QUO_W  = 20;
    localparam int C_MAG_W  = C_PROD_W + 1;

    // reciprocals for the span divisions
    localparam logic [C_RCP_W-1:0] C_RCP_LOW =
        C_RCP_W'(((64'd1 << C_RCP_K) + C_SPAN_LOW - 64'd1) / C_SPAN_LOW);
    localparam logic [C_RCP_W-1:0] C_RCP_HIGH =
        C_RCP_W'(((64'd1 << C_RCP_K) + C_SPAN_HIGH - 64'd1) / C_SPAN_HIGH);
    localparam logic [C_RCP_W-1:0] C_RCP_TOP =
        C_RCP_W'(((64'd1 << C_RCP_K) + C_SPAN_TOP - 64'd1) / C_SPAN_TOP);

    // time to Q2.30: 2^24 = 250 * C_T_QUOT + C_T_REM
    localparam int C_DT11_W  = 11;
    localparam int C_T_Y_W   = 19;
    localparam int C_T_RCP_K = 27;
    localparam int C_T_RCP_W = 20;
    localparam int C_T_MUL_W = C_T_Y_W + C_T_RCP_W;
    localparam logic [C_T_W-1:0]     C_T_QUOT = C_T_W'(64'd16777216 / 64'd250);
    localparam logic [C_T_Y_W-1:0]   C_T_REM  = C_T_Y_W'(64'd16777216 % 64'd250);
    localparam logic [C_T_Y_W-1:0]   C_T_BIAS = 19'd125;
    localparam logic [C_T_RCP_W-1:0] C_T_RCP  =
        C_T_RCP_W'(((64'd1 << C_T_RCP_K) + 64'd249) / 64'd250);

    // polynomial knots in Q2.30
    localparam logic [31:0] C_T20 = 32'((64'd320 * 64'd16777216 + 64'd125) / 64'd250);
    localparam logic [31:0] C_T90 = 32'((64'd1440 * 64'd16777216 + 64'd125) / 64'd250);

    // rounding terms
    localparam logic [63:0] C_HALF_Q30 = 64'd1 << 29;
    localparam logic [63:0] C_HALF_Q28 = 64'd1 << 27;
    localparam logic [63:0] C_UM_SCALE = 64'd1000;
    localparam logic [C_UM_W-1:0] C_UM_MAX = '1;

    localparam logic [C_OFF_W-1:0] C_OFFSET_RESET = 10'd17;

    // curve segment of one item
    typedef enum logic [2:0] {
        SEG_LOW,
        SEG_POLY,
        SEG_HIGH,
        SEG_TOP,
        SEG_FLAT
    } t_dt2r_seg;

    // sideband that rides along the polynomial pipeline
    typedef struct packed {
        t_dt2r_seg                  seg;
        logic signed [C_ACC_W-1:0]  f_line;
    } t_dt2r_side;

    // round(a * t / 2^30), halves away from zero
    function automatic logic signed [63:0] f_mul_q30(input logic signed [63:0] a,
                                                    input logic [31:0] t);
        logic        neg;
        logic [63:0] m;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] tt;
        logic [63:0] r;
        neg = a[63];
        m   = neg ? (64'd0 - 64'(a)) : 64'(a);
        hi  = {32'd0, m[63:32]};
        lo  = {32'd0, m[31:0]};
        tt  = {32'd0, t};
        r   = ((hi * tt) << 2) + ((lo * tt + C_HALF_Q30) >> 30);
        return neg ? signed'(64'd0 - r) : signed'(r);
    endfunction

    // horner evaluation at a fixed time, for knot values
    function automatic logic signed [63:0] f_poly(input int deg, input logic [31:0] t);
        logic signed [63:0] acc;
        int                 k;
        acc = C_COEF[deg];
        for (k = deg - 1; k >= 0; k--) begin
            acc = f_mul_q30(acc, t) + C_COEF[k];
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

/* sv/dt2r_horner_step.sv */
// ---------------------------------------------------------------------------
// dt2r_horner_step
// One Horner step acc' = round(acc * t / 2^30) + COEF over three register
// stages: magnitude, split partial products, recombine and add.
// ---------------------------------------------------------------------------
`default_nettype none

module dt2r_horner_step
    import dt2r_pkg::*;
#(
    parameter logic signed [C_ACC_W-1:0] COEF = 64'sd0
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic signed [C_ACC_W-1:0]  i_acc,
    input  wire logic [C_T_W-1:0]           i_t,
    input  wire t_dt2r_side                 i_side,
    output logic                            o_valid,
    output logic signed [C_ACC_W-1:0]       o_acc,
    output logic [C_T_W-1:0]                o_t,
    output t_dt2r_side                      o_side
);

    logic                       r_a_valid;
    logic                       r_a_neg;
    logic [C_ACC_W-1:0]         r_a_mag;
    logic [C_T_W-1:0]           r_a_t;
    t_dt2r_side                 r_a_side;
    logic                       r_b_valid;
    logic                       r_b_neg;
    logic [C_PP_W-1:0]          r_b_ph;
    logic [C_PP_W-1:0]          r_b_pl;
    logic [C_T_W-1:0]           r_b_t;
    t_dt2r_side                 r_b_side;
    logic                       r_c_valid;
    logic signed [C_ACC_W-1:0]  r_c_acc;
    logic [C_T_W-1:0]           r_c_t;
    t_dt2r_side                 r_c_side;

    logic [C_ACC_W-1:0]         n_a_mag;
    logic [C_PP_W-1:0]          n_b_ph;
    logic [C_PP_W-1:0]          n_b_pl;
    logic [C_ACC_W-1:0]         n_c_r;
    logic signed [C_ACC_W-1:0]  n_c_acc;

    // sign and magnitude of the accumulator
    assign n_a_mag = i_acc[C_ACC_W-1] ? (C_ACC_W'(0) - C_ACC_W'(i_acc)) : C_ACC_W'(i_acc);

    // upper and lower half products
    assign n_b_ph = C_PP_W'(r_a_mag[C_ACC_W-1:32]) * C_PP_W'(r_a_t);
    assign n_b_pl = C_PP_W'(r_a_mag[31:0]) * C_PP_W'(r_a_t);

    // recombine with rounding, restore sign, add coefficient
    always_comb begin
        n_c_r   = C_ACC_W'({r_b_ph, 2'b00})
                + C_ACC_W'((r_b_pl + C_PP_W'(C_HALF_Q30)) >> 30);
        n_c_acc = r_b_neg ? (COEF - signed'(n_c_r)) : (COEF + signed'(n_c_r));
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_neg  <= i_acc[C_ACC_W-1];
            r_a_mag  <= n_a_mag;
            r_a_t    <= i_t;
            r_a_side <= i_side;
            r_b_neg  <= r_a_neg;
            r_b_ph   <= n_b_ph;
            r_b_pl   <= n_b_pl;
            r_b_t    <= r_a_t;
            r_b_side <= r_a_side;
            r_c_acc  <= n_c_acc;
            r_c_t    <= r_b_t;
            r_c_side <= r_b_side;
        end
    end

    assign o_valid = r_c_valid;
    assign o_acc   = r_c_acc;
    assign o_t     = r_c_t;
    assign o_side  = r_c_side;

endmodule

`default_nettype wire

/* sv/drift_time_to_radius_parametric.sv */
// Throughput: one beat per cycle while the output is not stalled; each Horner step
// of the polynomial is three register stages, which sets most of the pipeline depth.
// An input skid register keeps taking one beat while the output is stalled.
// Reset clears all valid bits and loads the radius offset with 17 um.
// ---------------------------------------------------------------------------
// drift_time_to_radius_parametric
// Piecewise straw r(t) curve: knee line, polynomial, two lines and a flat
// top, followed by offset subtraction and clamping, fully pipelined.
// ---------------------------------------------------------------------------
`default_nettype none

module drift_time_to_radius_parametric
    import dt2r_pkg::*;
#(
    parameter int POLY_DEGREE = 9
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input stream
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [15:0]        i_s_axis_tdata,   // [15:0] drift_time
    // output stream
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [15:0]             o_m_axis_tdata,   // [12:0] radius_um, [15:13] zero
    // configuration
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [C_OFF_W-1:0] i_cfg_data        // radius_offset_um
);

    // knot values and line constants
    localparam logic signed [63:0] P20    = f_poly(POLY_DEGREE, C_T20);
    localparam logic signed [63:0] P90    = f_poly(POLY_DEGREE, C_T90);
    localparam logic signed [63:0] D_LOW  = P20;
    localparam logic signed [63:0] D_HIGH = C_V426 - P90;
    localparam logic signed [63:0] D_TOP  = C_VTOP - C_V426;
    localparam logic [63:0] A_LOW  = D_LOW[63]  ? 64'(-D_LOW)  : 64'(D_LOW);
    localparam logic [63:0] A_HIGH = D_HIGH[63] ? 64'(-D_HIGH) : 64'(D_HIGH);
    localparam logic [63:0] A_TOP  = D_TOP[63]  ? 64'(-D_TOP)  : 64'(D_TOP);
    localparam logic [C_QA_W-1:0] QA_LOW  = C_QA_W'(A_LOW / C_SPAN_LOW);
    localparam logic [C_QA_W-1:0] QA_HIGH = C_QA_W'(A_HIGH / C_SPAN_HIGH);
    localparam logic [C_QA_W-1:0] QA_TOP  = C_QA_W'(A_TOP / C_SPAN_TOP);
    localparam logic [C_RA_W-1:0] RA_LOW  = C_RA_W'(A_LOW % C_SPAN_LOW);
    localparam logic [C_RA_W-1:0] RA_HIGH = C_RA_W'(A_HIGH % C_SPAN_HIGH);
    localparam logic [C_RA_W-1:0] RA_TOP  = C_RA_W'(A_TOP % C_SPAN_TOP);

    // pipeline control
    logic                       w_en;
    logic                       w_accept;
    logic                       r_skid_valid;
    logic [C_DT_W-1:0]          r_skid_dt;
    logic [C_OFF_W-1:0]         r_radius_offset_um;

    // front end stages
    logic                       r_s0_valid;
    logic signed [C_DT_W-1:0]   r_s0_dt;

    logic                       r_s1_valid;
    t_dt2r_seg                  r_s1_seg;
    logic                       r_s1_n_neg;
    logic [C_NABS_W-1:0]        r_s1_n_abs;
    logic [C_T_W-1:0]           r_s1_ta;
    logic [C_T_Y_W-1:0]         r_s1_ty;
    t_dt2r_seg                  n_s1_seg;
    logic signed [C_DT_W:0]     n_s1_start;
    logic signed [C_DT_W:0]     n_s1_n;
    logic [C_DT11_W-1:0]        w_dt11;

    logic                       r_s2_valid;
    t_dt2r_seg                  r_s2_seg;
    logic                       r_s2_neg;
    logic [C_PROD_W-1:0]        r_s2_prod;
    logic [C_Y_W-1:0]           r_s2_y;
    logic [C_T_W-1:0]           r_s2_t;
    logic [C_QA_W-1:0]          n_s2_qa;
    logic [C_RA_W-1:0]          n_s2_ra;
    logic                       n_s2_dneg;
    logic [C_T_MUL_W-1:0]       n_s2_tq;

    logic                       r_s3_valid;
    t_dt2r_seg                  r_s3_seg;
    logic                       r_s3_neg;
    logic [C_PROD_W-1:0]        r_s3_prod;
    logic [C_QUO_W-1:0]         r_s3_quo;
    logic [C_T_W-1:0]           r_s3_t;
    logic [C_RCP_W-1:0]         n_s3_rcp;
    logic [C_RMUL_W-1:0]        n_s3_ymul;

    logic                       r_s4_valid;
    t_dt2r_seg                  r_s4_seg;
    logic                       r_s4_neg;
    logic [C_MAG_W-1:0]         r_s4_mag;
    logic [C_T_W-1:0]           r_s4_t;

    logic                       r_s5_valid;
    t_dt2r_seg                  r_s5_seg;
    logic signed [C_ACC_W-1:0]  r_s5_f;
    logic [C_T_W-1:0]           r_s5_t;
    logic signed [C_ACC_W-1:0]  n_s5_base;
    logic signed [C_ACC_W-1:0]  n_s5_mag;
    logic signed [C_ACC_W-1:0]  n_s5_f;

    // horner chain taps
    logic                       w_h_valid [0:POLY_DEGREE];
    logic signed [C_ACC_W-1:0]  w_h_acc   [0:POLY_DEGREE];
    logic [C_T_W-1:0]           w_h_t     [0:POLY_DEGREE];
    t_dt2r_side                 w_h_side  [0:POLY_DEGREE];

    // back end stages
    logic                       r_b1_valid;
    logic                       r_b1_neg;
    logic [C_ACC_W-1:0]         r_b1_mag;
    logic signed [C_ACC_W-1:0]  n_b1_f;

    logic                       r_b2_valid;
    logic                       r_b2_neg;
    logic [C_ACC_W-29:0]        r_b2_r;
    logic [C_ACC_W-1:0]         n_b2_scaled;

    logic                       r_out_valid;
    logic [C_UM_W-1:0]          r_out_um;
    logic [C_ACC_W-28:0]        n_out_diff;
    logic [C_UM_W-1:0]          n_out_um;

    // stall control: whole pipeline moves when the output slot is free
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_offset_um <= C_OFFSET_RESET;
        end else if (i_cfg_valid) begin
            r_radius_offset_um <= i_cfg_data;
        end
    end

    // skid and entry stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
            r_s0_valid   <= 1'b0;
        end else if (w_en) begin
            r_skid_valid <= 1'b0;
            r_s0_valid   <= r_skid_valid || w_accept;
        end else begin
            r_skid_valid <= r_skid_valid || w_accept;
        end
    end

    // skid and entry stage payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_dt <= r_skid_valid ? signed'(r_skid_dt) : signed'(i_s_axis_tdata);
        end else if (w_accept) begin
            r_skid_dt <= i_s_axis_tdata;
        end
    end

    // s1: segment decode, line offset, time conversion first half
    assign w_dt11 = r_s0_dt[C_DT11_W-1:0];
    always_comb begin
        n_s1_seg   = SEG_FLAT;
        n_s1_start = '0;
        priority if (r_s0_dt < C_DT_POLY_LO) begin
            n_s1_seg   = SEG_LOW;
            n_s1_start = (C_DT_W+1)'(C_DT_KNEE);
        end else if (r_s0_dt <= C_DT_POLY_HI) begin
            n_s1_seg   = SEG_POLY;
            n_s1_start = {r_s0_dt[C_DT_W-1], r_s0_dt};
        end else if (r_s0_dt <= C_DT_MID) begin
            n_s1_seg   = SEG_HIGH;
            n_s1_start = (C_DT_W+1)'(C_DT_POLY_HI);
        end else if (r_s0_dt <= C_DT_FLAT) begin
            n_s1_seg   = SEG_TOP;
            n_s1_start = (C_DT_W+1)'(C_DT_MID);
        end else begin
            n_s1_seg   = SEG_FLAT;
            n_s1_start = {r_s0_dt[C_DT_W-1], r_s0_dt};
        end
        n_s1_n = {r_s0_dt[C_DT_W-1], r_s0_dt} - n_s1_start;
    end

    // s2: select line constants, partial products, time conversion second half
    always_comb begin
        unique case (r_s1_seg)
            SEG_LOW: begin
                n_s2_qa   = QA_LOW;
                n_s2_ra   = RA_LOW;
                n_s2_dneg = D_LOW[63];
            end
            SEG_HIGH: begin
                n_s2_qa   = QA_HIGH;
                n_s2_ra   = RA_HIGH;
                n_s2_dneg = D_HIGH[63];
            end
            SEG_TOP: begin
                n_s2_qa   = QA_TOP;
                n_s2_ra   = RA_TOP;
                n_s2_dneg = D_TOP[63];
            end
            default: begin
                n_s2_qa   = '0;
                n_s2_ra   = '0;
                n_s2_dneg = 1'b0;
            end
        endcase
        n_s2_tq = C_T_MUL_W'(r_s1_ty) * C_T_MUL_W'(C_T_RCP);
    end

    // s3: remainder part of the span division by reciprocal
    always_comb begin
        unique case (r_s2_seg)
            SEG_LOW:  n_s3_rcp = C_RCP_LOW;
            SEG_HIGH: n_s3_rcp = C_RCP_HIGH;
            SEG_TOP:  n_s3_rcp = C_RCP_TOP;
            default:  n_s3_rcp = '0;
        endcase
        n_s3_ymul = C_RMUL_W'(r_s2_y) * C_RMUL_W'(n_s3_rcp);
    end

    // s5: signed line value on its base, knee line clamped at zero
    always_comb begin
        unique case (r_s4_seg)
            SEG_HIGH: n_s5_base = P90;
            SEG_TOP:  n_s5_base = C_V426;
            SEG_FLAT: n_s5_base = C_VTOP;
            default:  n_s5_base = '0;
        endcase
        n_s5_mag = signed'(C_ACC_W'(r_s4_mag));
        n_s5_f   = r_s4_neg ? (n_s5_base - n_s5_mag) : (n_s5_base + n_s5_mag);
        if ((r_s4_seg == SEG_LOW) && n_s5_f[C_ACC_W-1]) begin
            n_s5_f = '0;
        end
    end

    // front end valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    // front end payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_seg   <= n_s1_seg;
            r_s1_n_neg <= n_s1_n[C_DT_W];
            r_s1_n_abs <= n_s1_n[C_DT_W] ? C_NABS_W'((C_DT_W+1)'(0) - n_s1_n)
                                         : n_s1_n[C_NABS_W-1:0];
            r_s1_ta    <= C_T_QUOT * C_T_W'(w_dt11);
            r_s1_ty    <= C_T_REM * C_T_Y_W'(w_dt11) + C_T_BIAS;

            r_s2_seg   <= r_s1_seg;
            r_s2_neg   <= n_s2_dneg ^ r_s1_n_neg;
            r_s2_prod  <= C_PROD_W'(n_s2_qa) * C_PROD_W'(r_s1_n_abs);
            r_s2_y     <= C_Y_W'(n_s2_ra) * C_Y_W'(r_s1_n_abs);
            r_s2_t     <= r_s1_ta + C_T_W'(n_s2_tq >> C_T_RCP_K);

            r_s3_seg   <= r_s2_seg;
            r_s3_neg   <= r_s2_neg;
            r_s3_prod  <= r_s2_prod;
            r_s3_quo   <= C_QUO_W'(n_s3_ymul >> C_RCP_K);
            r_s3_t     <= r_s2_t;

            r_s4_seg   <= r_s3_seg;
            r_s4_neg   <= r_s3_neg;
            r_s4_mag   <= C_MAG_W'(r_s3_prod) + C_MAG_W'(r_s3_quo);
            r_s4_t     <= r_s3_t;

            r_s5_seg   <= r_s4_seg;
            r_s5_f     <= n_s5_f;
            r_s5_t     <= r_s4_t;
        end
    end

    // horner chain, highest coefficient first
    assign w_h_valid[0]       = r_s5_valid;
    assign w_h_acc[0]         = C_COEF[POLY_DEGREE];
    assign w_h_t[0]           = r_s5_t;
    assign w_h_side[0].seg    = r_s5_seg;
    assign w_h_side[0].f_line = r_s5_f;

    for (genvar gi = 0; gi < POLY_DEGREE; gi++) begin : g_horner
        dt2r_horner_step #(
            .COEF (C_COEF[POLY_DEGREE-1-gi])
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_h_valid[gi]),
            .i_acc   (w_h_acc[gi]),
            .i_t     (w_h_t[gi]),
            .i_side  (w_h_side[gi]),
            .o_valid (w_h_valid[gi+1]),
            .o_acc   (w_h_acc[gi+1]),
            .o_t     (w_h_t[gi+1]),
            .o_side  (w_h_side[gi+1])
        );
    end

    // b1: pick polynomial or line value, take magnitude
    assign n_b1_f = (w_h_side[POLY_DEGREE].seg == SEG_POLY) ? w_h_acc[POLY_DEGREE]
                                                            : w_h_side[POLY_DEGREE].f_line;

    // b2: scale to micrometres with rounding
    assign n_b2_scaled = r_b1_mag * C_UM_SCALE + C_HALF_Q28;

    // b3: offset subtraction and clamping
    always_comb begin
        n_out_diff = {1'b0, r_b2_r} - (C_ACC_W-27)'(r_radius_offset_um);
        if (r_b2_neg || n_out_diff[C_ACC_W-28]) begin
            n_out_um = '0;
        end else if (n_out_diff > (C_ACC_W-27)'(C_UM_MAX)) begin
            n_out_um = C_UM_MAX;
        end else begin
            n_out_um = n_out_diff[C_UM_W-1:0];
        end
    end

    // back end valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_b1_valid  <= w_h_valid[POLY_DEGREE];
            r_b2_valid  <= r_b1_valid;
            r_out_valid <= r_b2_valid;
        end
    end

    // back end payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_neg <= n_b1_f[C_ACC_W-1];
            r_b1_mag <= n_b1_f[C_ACC_W-1] ? (C_ACC_W'(0) - C_ACC_W'(n_b1_f))
                                          : C_ACC_W'(n_b1_f);
            r_b2_neg <= r_b1_neg;
            r_b2_r   <= n_b2_scaled[C_ACC_W-1:28];
            r_out_um <= n_out_um;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_um};

endmodule

`default_nettype wire
